// File: rtl/cpts_pkg.sv
// Package for the cable pi-model two-port solver.
// Holds the field widths, internal fixed-point formats, register indexes and
// the structs passed between modules. Depends on nothing.
`default_nettype none

package cpts_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CF         = 29;
    localparam int PW         = 24;
    localparam int LW         = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DW     = PW;

    localparam logic [CFG_IDX_W-1:0] REG_R   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_G   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEN = 3'd4;

    localparam int YW    = PW + LW;
    localparam int ZW    = YW + 1;
    localparam int YS    = YW / 2;
    localparam int ZPW   = ZW + YS;
    localparam int ZYFW  = ZW + YW + 2;
    localparam int ZYW   = ZYFW - CF;
    localparam int CPW   = ZYW + YS + 1;
    localparam int TFW   = ZYW + YW + 1;
    localparam int TW    = TFW - CF;
    localparam int CPREW = TW + 1;
    localparam int CW    = 64;

    localparam int KLO   = 32;
    localparam int KHI   = CW - KLO;
    localparam int PLW   = KLO + 1 + DATA_WIDTH;
    localparam int PHW   = KHI + DATA_WIDTH;
    localparam int SLW   = PLW + 2;
    localparam int SHW   = PHW + 2;
    localparam int AW    = SHW + KLO + 1;
    localparam int RW    = AW - CF;

    localparam int COEF_LAT = 6;
    localparam int SETTLE_W = $clog2(COEF_LAT + 1);

    typedef struct packed {
        logic [PW-1:0] r;
        logic [PW-1:0] x;
        logic [PW-1:0] g;
        logic [PW-1:0] b;
        logic [LW-1:0] len;
    } cpts_cfg_t;

    typedef struct packed {
        logic [CW-1:0] a_re;
        logic [CW-1:0] a_im;
        logic [CW-1:0] b_re;
        logic [CW-1:0] b_im;
        logic [CW-1:0] c_re;
        logic [CW-1:0] c_im;
        logic          clip;
    } cpts_coef_t;

    typedef struct packed {
        logic                  mode;
        logic [DATA_WIDTH-1:0] volt_re;
        logic [DATA_WIDTH-1:0] volt_im;
        logic [DATA_WIDTH-1:0] amp_re;
        logic [DATA_WIDTH-1:0] amp_im;
    } cpts_item_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] out_volt_re;
        logic [DATA_WIDTH-1:0] out_volt_im;
        logic [DATA_WIDTH-1:0] out_amp_re;
        logic [DATA_WIDTH-1:0] out_amp_im;
        logic                  clipped;
    } cpts_res_t;

endpackage

`default_nettype wire

// File: rtl/cpts_if.sv
// Channel interfaces of the cable pi-model two-port solver: phasor requests,
// results and configuration writes. Depends on cpts_pkg.
`default_nettype none

interface cpts_item_if;
    import cpts_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic signed [DATA_WIDTH-1:0] volt_re;
    logic signed [DATA_WIDTH-1:0] volt_im;
    logic signed [DATA_WIDTH-1:0] amp_re;
    logic signed [DATA_WIDTH-1:0] amp_im;

    modport source (
        output valid, mode, volt_re, volt_im, amp_re, amp_im,
        input  ready
    );
    modport sink (
        input  valid, mode, volt_re, volt_im, amp_re, amp_im,
        output ready
    );
endinterface

interface cpts_res_if;
    import cpts_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] out_volt_re;
    logic signed [DATA_WIDTH-1:0] out_volt_im;
    logic signed [DATA_WIDTH-1:0] out_amp_re;
    logic signed [DATA_WIDTH-1:0] out_amp_im;
    logic                         clipped;

    modport source (
        output valid, out_volt_re, out_volt_im, out_amp_re, out_amp_im, clipped,
        input  ready
    );
    modport sink (
        input  valid, out_volt_re, out_volt_im, out_amp_re, out_amp_im, clipped,
        output ready
    );
endinterface

interface cpts_cfg_if;
    import cpts_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DW-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/cpts_coef.sv
// Free-running six-stage pipeline that derives the ABCD coefficients from the
// line parameters. Depends on cpts_pkg.
`default_nettype none

module cpts_coef (
    input  logic                   clk,
    input  cpts_pkg::cpts_cfg_t    cfg,
    output cpts_pkg::cpts_coef_t   coef
);
    import cpts_pkg::*;

    localparam logic [ZYFW-1:0] RND_ZY = ZYFW'(1) << (CF - 1);
    localparam logic [TFW-1:0]  RND_T  = TFW'(1) << (CF - 1);
    localparam logic [ZYW-1:0]  ONE    = ZYW'(1) << CF;
    localparam logic signed [CPREW-1:0] C_MAX = CPREW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [CPREW-1:0] C_MIN = -C_MAX;

    logic [YW-1:0]  zr_reg;
    logic [YW-1:0]  zi_reg;
    logic [YW-1:0]  yr_reg;
    logic [YW-1:0]  yi_reg;
    logic [ZW-1:0]  z_re;
    logic [ZW-1:0]  z_im;
    logic [ZW-1:0]  zop [4];
    logic [YW-1:0]  yop [4];
    logic [ZPW-1:0] pz_reg [4][2];

    logic signed [ZYFW-1:0] f_re;
    logic signed [ZYFW-1:0] f_im;
    logic signed [ZYW-1:0]  zy_re_reg;
    logic signed [ZYW-1:0]  zy_im_reg;
    logic signed [ZYW-1:0]  zyop [4];
    logic signed [ZYW-1:0]  a_re_reg;
    logic signed [ZYW-1:0]  a_im_reg;
    logic signed [CPW-1:0]  pc_reg [4][2];

    logic signed [TFW-1:0]   tf_re;
    logic signed [TFW-1:0]   tf_im;
    logic signed [TW-1:0]    t_re_reg;
    logic signed [TW-1:0]    t_im_reg;
    logic signed [CPREW-1:0] cp_re;
    logic signed [CPREW-1:0] cp_im;
    logic [CW-1:0]           c_re_reg;
    logic [CW-1:0]           c_im_reg;
    logic                    clip_reg;

    // Per-length products; the series term carries the factor of two.
    always_ff @(posedge clk)
    begin
        zr_reg <= cfg.r * cfg.len;
        zi_reg <= cfg.x * cfg.len;
        yr_reg <= cfg.g * cfg.len;
        yi_reg <= cfg.b * cfg.len;
    end

    assign z_re = {zr_reg, 1'b0};
    assign z_im = {zi_reg, 1'b0};

    always_comb
    begin
        zop[0] = z_re;
        yop[0] = yr_reg;
        zop[1] = z_im;
        yop[1] = yi_reg;
        zop[2] = z_re;
        yop[2] = yi_reg;
        zop[3] = z_im;
        yop[3] = yr_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 4; j++)
        begin
            pz_reg[j][0] <= zop[j] * yop[j][YS-1:0];
            pz_reg[j][1] <= zop[j] * yop[j][YW-1:YS];
        end
    end

    always_comb
    begin
        f_re = ((ZYFW'(pz_reg[0][1]) - ZYFW'(pz_reg[1][1])) << YS)
             + ZYFW'(pz_reg[0][0]) - ZYFW'(pz_reg[1][0]) + RND_ZY;
        f_im = ((ZYFW'(pz_reg[2][1]) + ZYFW'(pz_reg[3][1])) << YS)
             + ZYFW'(pz_reg[2][0]) + ZYFW'(pz_reg[3][0]) + RND_ZY;
    end

    always_ff @(posedge clk)
    begin
        zy_re_reg <= ZYW'(f_re >>> CF);
        zy_im_reg <= ZYW'(f_im >>> CF);
    end

    always_comb
    begin
        zyop[0] = zy_re_reg;
        zyop[1] = zy_im_reg;
        zyop[2] = zy_re_reg;
        zyop[3] = zy_im_reg;
    end

    always_ff @(posedge clk)
    begin
        a_re_reg <= zy_re_reg + ONE;
        a_im_reg <= zy_im_reg;
        for (int j = 0; j < 4; j++)
        begin
            pc_reg[j][0] <= zyop[j] * $signed({1'b0, yop[j][YS-1:0]});
            pc_reg[j][1] <= zyop[j] * $signed({1'b0, yop[j][YW-1:YS]});
        end
    end

    always_comb
    begin
        tf_re = ((TFW'(pc_reg[0][1]) - TFW'(pc_reg[1][1])) << YS)
              + TFW'(pc_reg[0][0]) - TFW'(pc_reg[1][0]) + RND_T;
        tf_im = ((TFW'(pc_reg[2][1]) + TFW'(pc_reg[3][1])) << YS)
              + TFW'(pc_reg[2][0]) + TFW'(pc_reg[3][0]) + RND_T;
    end

    always_ff @(posedge clk)
    begin
        t_re_reg <= TW'(tf_re >>> CF);
        t_im_reg <= TW'(tf_im >>> CF);
    end

    always_comb
    begin
        cp_re = CPREW'(t_re_reg) + CPREW'({yr_reg, 1'b0});
        cp_im = CPREW'(t_im_reg) + CPREW'({yi_reg, 1'b0});
    end

    // The shunt coefficient is clamped symmetrically so that its negation fits.
    always_ff @(posedge clk)
    begin
        if (cp_re > C_MAX)
        begin
            c_re_reg <= CW'(C_MAX);
        end
        else if (cp_re < C_MIN)
        begin
            c_re_reg <= CW'(C_MIN);
        end
        else
        begin
            c_re_reg <= CW'(cp_re);
        end
        if (cp_im > C_MAX)
        begin
            c_im_reg <= CW'(C_MAX);
        end
        else if (cp_im < C_MIN)
        begin
            c_im_reg <= CW'(C_MIN);
        end
        else
        begin
            c_im_reg <= CW'(cp_im);
        end
        clip_reg <= (cp_re > C_MAX) || (cp_re < C_MIN) || (cp_im > C_MAX) || (cp_im < C_MIN);
    end

    always_comb
    begin
        coef.a_re = CW'(a_re_reg);
        coef.a_im = CW'(a_im_reg);
        coef.b_re = CW'(z_re);
        coef.b_im = CW'(z_im);
        coef.c_re = c_re_reg;
        coef.c_im = c_im_reg;
        coef.clip = clip_reg;
    end

endmodule

`default_nettype wire

// File: rtl/cpts_mac.sv
// Five-stage phasor datapath: coefficient selection, split partial products,
// signed sums, recombination with rounding, and saturation. Depends on cpts_pkg.
`default_nettype none

module cpts_mac (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  cpts_pkg::cpts_item_t   item,
    input  cpts_pkg::cpts_coef_t   coef,
    output logic                   res_valid,
    input  logic                   res_ready,
    output cpts_pkg::cpts_res_t    res
);
    import cpts_pkg::*;

    localparam logic [3:0] SUB_MASK [4] = '{4'b1010, 4'b0000, 4'b1010, 4'b0000};
    localparam logic [AW-1:0] RND = AW'(1) << (CF - 1);
    localparam logic signed [RW-1:0] SAT_MAX = RW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam logic signed [RW-1:0] SAT_MIN = ~SAT_MAX;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;
    logic clip1_reg, clip2_reg, clip3_reg, clip4_reg, clip5_reg;

    logic signed [DATA_WIDTH-1:0] u_re_reg, u_im_reg, i_re_reg, i_im_reg;
    logic signed [CW-1:0] ka_re_reg, ka_im_reg, kb_re_reg, kb_im_reg, kc_re_reg, kc_im_reg;

    logic signed [CW-1:0]         kop [4][4];
    logic signed [DATA_WIDTH-1:0] dop [4][4];
    logic signed [PLW-1:0]        plo_reg [4][4];
    logic signed [PHW-1:0]        phi_reg [4][4];
    logic signed [SLW-1:0]        lo_sum_next [4];
    logic signed [SHW-1:0]        hi_sum_next [4];
    logic signed [SLW-1:0]        lo_sum_reg [4];
    logic signed [SHW-1:0]        hi_sum_reg [4];
    logic signed [AW-1:0]         acc_next [4];
    logic signed [RW-1:0]         rnd_reg [4];
    logic [DATA_WIDTH-1:0]        out_reg [4];
    logic [3:0]                   sat_hit;

    assign en5        = !v5_reg || res_ready;
    assign en4        = !v4_reg || en5;
    assign en3        = !v3_reg || en4;
    assign en2        = !v2_reg || en3;
    assign en1        = !v1_reg || en2;
    assign item_ready = en1;
    assign res_valid  = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= item_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Sending-end to receiving-end flips the signs of B and C.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            u_re_reg  <= $signed(item.volt_re);
            u_im_reg  <= $signed(item.volt_im);
            i_re_reg  <= $signed(item.amp_re);
            i_im_reg  <= $signed(item.amp_im);
            ka_re_reg <= $signed(coef.a_re);
            ka_im_reg <= $signed(coef.a_im);
            kb_re_reg <= item.mode ? -$signed(coef.b_re) : $signed(coef.b_re);
            kb_im_reg <= item.mode ? -$signed(coef.b_im) : $signed(coef.b_im);
            kc_re_reg <= item.mode ? -$signed(coef.c_re) : $signed(coef.c_re);
            kc_im_reg <= item.mode ? -$signed(coef.c_im) : $signed(coef.c_im);
            clip1_reg <= coef.clip;
        end
    end

    always_comb
    begin
        kop[0] = '{ka_re_reg, ka_im_reg, kb_re_reg, kb_im_reg};
        kop[1] = '{ka_re_reg, ka_im_reg, kb_re_reg, kb_im_reg};
        kop[2] = '{kc_re_reg, kc_im_reg, ka_re_reg, ka_im_reg};
        kop[3] = '{kc_re_reg, kc_im_reg, ka_re_reg, ka_im_reg};
        dop[0] = '{u_re_reg, u_im_reg, i_re_reg, i_im_reg};
        dop[1] = '{u_im_reg, u_re_reg, i_im_reg, i_re_reg};
        dop[2] = '{u_re_reg, u_im_reg, i_re_reg, i_im_reg};
        dop[3] = '{u_im_reg, u_re_reg, i_im_reg, i_re_reg};
    end

    // Each coefficient is split into an unsigned low word and a signed high word.
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            for (int n = 0; n < 4; n++)
            begin
                for (int t = 0; t < 4; t++)
                begin
                    plo_reg[n][t] <= $signed({1'b0, kop[n][t][KLO-1:0]}) * dop[n][t];
                    phi_reg[n][t] <= $signed(kop[n][t][CW-1:KLO]) * dop[n][t];
                end
            end
            clip2_reg <= clip1_reg;
        end
    end

    always_comb
    begin
        for (int n = 0; n < 4; n++)
        begin
            lo_sum_next[n] = '0;
            hi_sum_next[n] = '0;
            for (int t = 0; t < 4; t++)
            begin
                if (SUB_MASK[n][t])
                begin
                    lo_sum_next[n] = lo_sum_next[n] - SLW'(plo_reg[n][t]);
                    hi_sum_next[n] = hi_sum_next[n] - SHW'(phi_reg[n][t]);
                end
                else
                begin
                    lo_sum_next[n] = lo_sum_next[n] + SLW'(plo_reg[n][t]);
                    hi_sum_next[n] = hi_sum_next[n] + SHW'(phi_reg[n][t]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            for (int n = 0; n < 4; n++)
            begin
                lo_sum_reg[n] <= lo_sum_next[n];
                hi_sum_reg[n] <= hi_sum_next[n];
            end
            clip3_reg <= clip2_reg;
        end
    end

    always_comb
    begin
        for (int n = 0; n < 4; n++)
        begin
            acc_next[n] = (AW'(hi_sum_reg[n]) << KLO) + AW'(lo_sum_reg[n]) + RND;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            for (int n = 0; n < 4; n++)
            begin
                rnd_reg[n] <= RW'(acc_next[n] >>> CF);
            end
            clip4_reg <= clip3_reg;
        end
    end

    always_comb
    begin
        for (int n = 0; n < 4; n++)
        begin
            sat_hit[n] = (rnd_reg[n] > SAT_MAX) || (rnd_reg[n] < SAT_MIN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            for (int n = 0; n < 4; n++)
            begin
                if (rnd_reg[n] > SAT_MAX)
                begin
                    out_reg[n] <= DATA_WIDTH'(SAT_MAX);
                end
                else if (rnd_reg[n] < SAT_MIN)
                begin
                    out_reg[n] <= DATA_WIDTH'(SAT_MIN);
                end
                else
                begin
                    out_reg[n] <= DATA_WIDTH'(rnd_reg[n]);
                end
            end
            clip5_reg <= clip4_reg || (|sat_hit);
        end
    end

    always_comb
    begin
        res.out_volt_re = out_reg[0];
        res.out_volt_im = out_reg[1];
        res.out_amp_re  = out_reg[2];
        res.out_amp_im  = out_reg[3];
        res.clipped     = clip5_reg;
    end

endmodule

`default_nettype wire

// File: rtl/cable_pi_two_port_solver.sv
// Top level of the cable pi-model two-port solver: configuration registers,
// coefficient pipeline and phasor datapath. Depends on cpts_pkg, cpts_if,
// cpts_coef and cpts_mac.
//
//   Channel  Role    Handshake     Payload
//   item     sink    valid/ready   mode, volt_re, volt_im, amp_re, amp_im
//   result   source  valid/ready   out_volt_re, out_volt_im, out_amp_re,
//                                  out_amp_im, clipped
//   cfg      sink    valid/ready   index, data (always ready)
//
// One request is taken per cycle once the coefficients have settled, unless a stalled
// result has filled the phasor datapath, which is five register stages deep.
// The coefficient pipeline is six stages deep, so requests are held off after
// reset and after every configuration write until it has settled.
// A stalled result holds the last stage; earlier empty stages keep filling.
// Reset clears the configuration registers to zero and empties the datapath.
`default_nettype none

module cable_pi_two_port_solver (
    input  logic        clk,
    input  logic        rst_n,
    cpts_item_if.sink   item,
    cpts_res_if.source  result,
    cpts_cfg_if.sink    cfg
);
    import cpts_pkg::*;

    logic [PW-1:0]       r_reg;
    logic [PW-1:0]       x_reg;
    logic [PW-1:0]       g_reg;
    logic [PW-1:0]       b_reg;
    logic [LW-1:0]       len_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic                settled;
    logic                mac_ready;
    logic                mac_res_valid;
    cpts_cfg_t           cfg_word;
    cpts_coef_t          coef;
    cpts_item_t          item_word;
    cpts_res_t           res_word;

    assign cfg.ready = 1'b1;
    assign settled   = (settle_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg      <= '0;
            x_reg      <= '0;
            g_reg      <= '0;
            b_reg      <= '0;
            len_reg    <= '0;
            settle_reg <= SETTLE_W'(COEF_LAT);
        end
        else
        begin
            if (cfg.valid)
            begin
                settle_reg <= SETTLE_W'(COEF_LAT);
                case (cfg.index)
                    REG_R:   r_reg   <= cfg.data;
                    REG_X:   x_reg   <= cfg.data;
                    REG_G:   g_reg   <= cfg.data;
                    REG_B:   b_reg   <= cfg.data;
                    REG_LEN: len_reg <= cfg.data[LW-1:0];
                    default: ;
                endcase
            end
            else if (!settled)
            begin
                settle_reg <= settle_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        cfg_word.r   = r_reg;
        cfg_word.x   = x_reg;
        cfg_word.g   = g_reg;
        cfg_word.b   = b_reg;
        cfg_word.len = len_reg;

        item_word.mode    = item.mode;
        item_word.volt_re = item.volt_re;
        item_word.volt_im = item.volt_im;
        item_word.amp_re  = item.amp_re;
        item_word.amp_im  = item.amp_im;
    end

    cpts_coef u_coef (
        .clk  (clk),
        .cfg  (cfg_word),
        .coef (coef)
    );

    cpts_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid && settled),
        .item_ready (mac_ready),
        .item       (item_word),
        .coef       (coef),
        .res_valid  (mac_res_valid),
        .res_ready  (result.ready),
        .res        (res_word)
    );

    assign item.ready         = mac_ready && settled;
    assign result.valid       = mac_res_valid;
    assign result.out_volt_re = res_word.out_volt_re;
    assign result.out_volt_im = res_word.out_volt_im;
    assign result.out_amp_re  = res_word.out_amp_re;
    assign result.out_amp_im  = res_word.out_amp_im;
    assign result.clipped     = res_word.clipped;

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the cable pi-model two-port solver: a directed table
// and random phasor requests, checked against a predictor of the two-port equations.
// Depends on cpts_pkg, the channel interfaces in cpts_if and the solver's top level.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpts_pkg::*;

    typedef logic signed [127:0] acc_t;
    typedef logic signed [63:0]  coef_t;

    typedef struct packed {
        logic [1:0] setting;
        logic       typed;
        cpts_item_t stim;
        cpts_res_t  want;
    } dir_row_t;

    localparam acc_t COEF_MAX = (acc_t'(1) <<< 63) - acc_t'(1);
    localparam acc_t COEF_MIN = -COEF_MAX;
    localparam acc_t DATA_MAX = (acc_t'(1) <<< (DATA_WIDTH - 1)) - acc_t'(1);
    localparam acc_t DATA_MIN = -(acc_t'(1) <<< (DATA_WIDTH - 1));

    localparam logic [DATA_WIDTH-1:0] Q_MAX     = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] Q_MIN     = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] Q_ONE     = 32'h0001_0000;
    localparam logic [DATA_WIDTH-1:0] Q_NEG_ONE = 32'hFFFF_0000;
    localparam logic [DATA_WIDTH-1:0] Q_HALF    = 32'h0000_8000;

    localparam logic TO_SENDING   = 1'b0;
    localparam logic TO_RECEIVING = 1'b1;

    localparam int SET_RESET = 0;
    localparam int SET_MAX   = 1;
    localparam int SET_UNIT  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_LEN + CFG_IDX_W'(1);

    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int MAX_REPORTS     = 100;
    localparam int TIMEOUT_NS      = 2_000_000;

    logic clk;
    logic rst_n;

    cpts_item_if item_ch ();
    cpts_res_if  res_ch ();
    cpts_cfg_if  cfg_ch ();

    cable_pi_two_port_solver dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    cpts_res_t  far_end_due[$];
    dir_row_t   dir_rows[$];
    cpts_cfg_t  dir_cfg[3];
    cpts_cfg_t  line_cfg;
    int         err_count = 0;
    int         burst_left;
    int         hold_ask = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL cable_pi_two_port_solver");
        $finish;
    end

    function automatic acc_t mul_wide(input coef_t p, input coef_t q);
        acc_t wp;
        acc_t wq;
        wp = p;
        wq = q;
        return wp * wq;
    endfunction

    function automatic acc_t round_cf(input acc_t v);
        return (v + (acc_t'(1) <<< (CF - 1))) >>> CF;
    endfunction

    function automatic coef_t clamp_coef(input acc_t v);
        if (v > COEF_MAX)
            return COEF_MAX[63:0];
        if (v < COEF_MIN)
            return COEF_MIN[63:0];
        return v[63:0];
    endfunction

    function automatic logic [DATA_WIDTH-1:0] clamp_data(input acc_t v);
        if (v > DATA_MAX)
            return DATA_MAX[DATA_WIDTH-1:0];
        if (v < DATA_MIN)
            return DATA_MIN[DATA_WIDTH-1:0];
        return v[DATA_WIDTH-1:0];
    endfunction

    function automatic logic data_clips(input acc_t v);
        return (v > DATA_MAX) || (v < DATA_MIN);
    endfunction

    function automatic cpts_res_t solve_far_end(input cpts_cfg_t cf, input cpts_item_t it);
        coef_t     z_re, z_im, y_re, y_im, zy_re, zy_im;
        coef_t     a_re, a_im, b_re, b_im, c_re, c_im;
        coef_t     u_re, u_im, i_re, i_im;
        acc_t      s;
        logic      clip;
        cpts_res_t res;
        clip = 1'b0;
        z_re = (64'(cf.r) * 64'(cf.len)) << 1;
        z_im = (64'(cf.x) * 64'(cf.len)) << 1;
        y_re = 64'(cf.g) * 64'(cf.len);
        y_im = 64'(cf.b) * 64'(cf.len);
        s = round_cf(mul_wide(z_re, y_re) - mul_wide(z_im, y_im));
        zy_re = s[63:0];
        s = round_cf(mul_wide(z_re, y_im) + mul_wide(z_im, y_re));
        zy_im = s[63:0];
        a_re = zy_re + (coef_t'(1) <<< CF);
        a_im = zy_im;
        b_re = z_re;
        b_im = z_im;
        s = round_cf(mul_wide(zy_re, y_re) - mul_wide(zy_im, y_im)) + acc_t'(y_re <<< 1);
        c_re = clamp_coef(s);
        clip |= (acc_t'(c_re) != s);
        s = round_cf(mul_wide(zy_re, y_im) + mul_wide(zy_im, y_re)) + acc_t'(y_im <<< 1);
        c_im = clamp_coef(s);
        clip |= (acc_t'(c_im) != s);
        if (it.mode == TO_RECEIVING)
        begin
            b_re = -b_re;
            b_im = -b_im;
            c_re = -c_re;
            c_im = -c_im;
        end
        u_re = $signed(it.volt_re);
        u_im = $signed(it.volt_im);
        i_re = $signed(it.amp_re);
        i_im = $signed(it.amp_im);
        s = round_cf(mul_wide(a_re, u_re) - mul_wide(a_im, u_im)
                     + mul_wide(b_re, i_re) - mul_wide(b_im, i_im));
        res.out_volt_re = clamp_data(s);
        clip |= data_clips(s);
        s = round_cf(mul_wide(a_re, u_im) + mul_wide(a_im, u_re)
                     + mul_wide(b_re, i_im) + mul_wide(b_im, i_re));
        res.out_volt_im = clamp_data(s);
        clip |= data_clips(s);
        s = round_cf(mul_wide(c_re, u_re) - mul_wide(c_im, u_im)
                     + mul_wide(a_re, i_re) - mul_wide(a_im, i_im));
        res.out_amp_re = clamp_data(s);
        clip |= data_clips(s);
        s = round_cf(mul_wide(c_re, u_im) + mul_wide(c_im, u_re)
                     + mul_wide(a_re, i_im) + mul_wide(a_im, i_re));
        res.out_amp_im = clamp_data(s);
        clip |= data_clips(s);
        res.clipped = clip;
        return res;
    endfunction

    function automatic cpts_item_t mk_item(input logic mode, input logic [DATA_WIDTH-1:0] vr,
                                           input logic [DATA_WIDTH-1:0] vi,
                                           input logic [DATA_WIDTH-1:0] ar,
                                           input logic [DATA_WIDTH-1:0] ai);
        cpts_item_t it;
        it.mode    = mode;
        it.volt_re = vr;
        it.volt_im = vi;
        it.amp_re  = ar;
        it.amp_im  = ai;
        return it;
    endfunction

    function automatic cpts_res_t mk_res(input logic [DATA_WIDTH-1:0] vr,
                                         input logic [DATA_WIDTH-1:0] vi,
                                         input logic [DATA_WIDTH-1:0] ar,
                                         input logic [DATA_WIDTH-1:0] ai, input logic clip);
        cpts_res_t r;
        r.out_volt_re = vr;
        r.out_volt_im = vi;
        r.out_amp_re  = ar;
        r.out_amp_im  = ai;
        r.clipped     = clip;
        return r;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_phasor_part();
        logic [DATA_WIDTH-1:0] v;
        case ($urandom_range(0, 9))
            0: v = Q_MAX;
            1: v = Q_MIN;
            2: v = '0;
            3, 4, 5:
            begin
                v = DATA_WIDTH'($urandom_range(0, 32'h0020_0000));
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            default: v = DATA_WIDTH'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [PW-1:0] rand_reg();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return PW'($urandom_range(0, 4095));
            default: return PW'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [DATA_WIDTH-1:0] got,
                               input logic [DATA_WIDTH-1:0] want, input int n);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %h, expected %h", n, name, got, want));
    endtask

    task automatic add_row(input int setting, input cpts_item_t stim, input logic typed,
                           input cpts_res_t want);
        dir_row_t row;
        row.setting = 2'(setting);
        row.typed   = typed;
        row.stim    = stim;
        row.want    = want;
        dir_rows.push_back(row);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        case (idx)
            REG_R:   line_cfg.r   = val;
            REG_X:   line_cfg.x   = val;
            REG_G:   line_cfg.g   = val;
            REG_B:   line_cfg.b   = val;
            REG_LEN: line_cfg.len = val[LW-1:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(input cpts_cfg_t s);
        logic [CFG_DW-1:0] len_word;
        len_word = CFG_DW'($urandom);
        len_word[LW-1:0] = s.len;
        write_reg(REG_R, s.r);
        write_reg(REG_X, s.x);
        write_reg(REG_UNUSED + CFG_IDX_W'($urandom_range(0, 2)), CFG_DW'($urandom));
        write_reg(REG_G, s.g);
        write_reg(REG_B, s.b);
        write_reg(REG_LEN, len_word);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic push_item(input cpts_item_t it, input logic typed, input cpts_res_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_ch.valid   <= 1'b1;
        item_ch.mode    <= it.mode;
        item_ch.volt_re <= it.volt_re;
        item_ch.volt_im <= it.volt_im;
        item_ch.amp_re  <= it.amp_re;
        item_ch.amp_im  <= it.amp_im;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        far_end_due.push_back(typed ? want : solve_far_end(line_cfg, it));
    endtask

    task automatic end_burst();
        item_ch.valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        while (far_end_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (far_end_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", far_end_due.size()));
            far_end_due.delete();
        end
    endtask

    initial
    begin : result_sink
        cpts_res_t got;
        cpts_res_t want;
        int        seen;
        int        seg_left;
        int        seg_kind;
        int        hold_left;
        int        hold_seen;
        res_ch.ready <= 1'b0;
        seen = 0;
        seg_left = 0;
        seg_kind = 0;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                got = mk_res(res_ch.out_volt_re, res_ch.out_volt_im, res_ch.out_amp_re,
                             res_ch.out_amp_im, res_ch.clipped);
                if (far_end_due.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with no request open", seen));
                else
                begin
                    want = far_end_due.pop_front();
                    check_field("out_volt_re", got.out_volt_re, want.out_volt_re, seen);
                    check_field("out_volt_im", got.out_volt_im, want.out_volt_im, seen);
                    check_field("out_amp_re", got.out_amp_re, want.out_amp_re, seen);
                    check_field("out_amp_im", got.out_amp_im, want.out_amp_im, seen);
                    check_field("clipped", DATA_WIDTH'(got.clipped), DATA_WIDTH'(want.clipped),
                                seen);
                end
                seen++;
            end
            if (hold_ask != hold_seen)
            begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_kind = $urandom_range(0, 3);
                    seg_left = $urandom_range(1, 60);
                end
                seg_left--;
                case (seg_kind)
                    0, 1:    res_ch.ready <= 1'b1;
                    2:       res_ch.ready <= 1'($urandom_range(0, 1));
                    default: res_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        cpts_item_t it;
        cpts_cfg_t  set_cfg;
        int         cur_set;
        int         phase;
        rst_n           <= 1'b0;
        item_ch.valid   <= 1'b0;
        item_ch.mode    <= TO_SENDING;
        item_ch.volt_re <= '0;
        item_ch.volt_im <= '0;
        item_ch.amp_re  <= '0;
        item_ch.amp_im  <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= REG_R;
        cfg_ch.data     <= '0;
        line_cfg = '0;
        burst_left = 0;

        dir_cfg[SET_RESET] = '0;
        dir_cfg[SET_MAX]   = '1;
        dir_cfg[SET_UNIT]  = '0;
        dir_cfg[SET_UNIT].r   = PW'(1) << 20;
        dir_cfg[SET_UNIT].len = LW'(1) << 8;

        // With every register at zero the two-port is the identity.
        add_row(SET_RESET, mk_item(TO_SENDING, '0, '0, '0, '0), 1'b1,
                mk_res('0, '0, '0, '0, 1'b0));
        add_row(SET_RESET, mk_item(TO_SENDING, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b1,
                mk_res(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0));
        add_row(SET_RESET, mk_item(TO_RECEIVING, Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b1,
                mk_res(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0));
        add_row(SET_RESET, mk_item(TO_RECEIVING, Q_ONE, Q_NEG_ONE, Q_MAX, Q_MIN), 1'b1,
                mk_res(Q_ONE, Q_NEG_ONE, Q_MAX, Q_MIN, 1'b0));
        add_row(SET_RESET, mk_item(TO_SENDING, 32'h1234_5678, 32'hFEDC_BA98, 32'h1, '1), 1'b1,
                mk_res(32'h1234_5678, 32'hFEDC_BA98, 32'h1, '1, 1'b0));

        // Every register at its maximum saturates the shunt coefficient.
        add_row(SET_MAX, mk_item(TO_SENDING, '0, '0, '0, '0), 1'b1,
                mk_res('0, '0, '0, '0, 1'b1));
        add_row(SET_MAX, mk_item(TO_RECEIVING, '0, '0, '0, '0), 1'b1,
                mk_res('0, '0, '0, '0, 1'b1));
        add_row(SET_MAX, mk_item(TO_SENDING, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b0, '0);
        add_row(SET_MAX, mk_item(TO_RECEIVING, Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b0, '0);
        add_row(SET_MAX, mk_item(TO_SENDING, Q_ONE, '0, '0, '0), 1'b0, '0);
        add_row(SET_MAX, mk_item(TO_RECEIVING, 32'h1, 32'h1, Q_NEG_ONE, 32'h1), 1'b0, '0);

        // A unit series impedance with no shunt: a = d = 1, b = 1, c = 0.
        add_row(SET_UNIT, mk_item(TO_SENDING, Q_ONE, '0, 32'h0002_0000, '0), 1'b1,
                mk_res(32'h0003_0000, '0, 32'h0002_0000, '0, 1'b0));
        add_row(SET_UNIT, mk_item(TO_RECEIVING, 32'h0003_0000, '0, Q_ONE, Q_ONE), 1'b1,
                mk_res(32'h0002_0000, Q_NEG_ONE, Q_ONE, Q_ONE, 1'b0));
        add_row(SET_UNIT, mk_item(TO_SENDING, Q_MAX, '0, Q_ONE, '0), 1'b1,
                mk_res(Q_MAX, '0, Q_ONE, '0, 1'b1));
        add_row(SET_UNIT, mk_item(TO_RECEIVING, Q_MIN, '0, Q_ONE, '0), 1'b1,
                mk_res(Q_MIN, '0, Q_ONE, '0, 1'b1));
        add_row(SET_UNIT, mk_item(TO_SENDING, Q_MAX, Q_MIN, Q_MIN, Q_MAX), 1'b1,
                mk_res('1, '1, Q_MIN, Q_MAX, 1'b0));
        add_row(SET_UNIT, mk_item(TO_SENDING, Q_HALF, Q_HALF, Q_HALF, Q_HALF), 1'b0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        cur_set = SET_RESET;
        foreach (dir_rows[n])
        begin
            if (int'(dir_rows[n].setting) != cur_set)
            begin
                end_burst();
                drain();
                cur_set = int'(dir_rows[n].setting);
                load_setting(dir_cfg[cur_set]);
            end
            push_item(dir_rows[n].stim, dir_rows[n].typed, dir_rows[n].want);
        end

        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            end_burst();
            drain();
            case (phase)
                0: set_cfg = '1;
                1: set_cfg = '0;
                2:
                begin
                    set_cfg = '1;
                    set_cfg.len = '0;
                end
                3:
                begin
                    set_cfg.r   = PW'($urandom_range(0, 1 << 18));
                    set_cfg.x   = PW'($urandom_range(0, 1 << 18));
                    set_cfg.g   = PW'($urandom_range(0, 1 << 12));
                    set_cfg.b   = PW'($urandom_range(0, 1 << 14));
                    set_cfg.len = LW'($urandom_range(1, 1 << 12));
                end
                default:
                begin
                    set_cfg.r   = rand_reg();
                    set_cfg.x   = rand_reg();
                    set_cfg.g   = rand_reg();
                    set_cfg.b   = rand_reg();
                    set_cfg.len = LW'(rand_reg());
                end
            endcase
            load_setting(set_cfg);
            if (phase == 2 || phase == 5)
                hold_ask++;
            repeat (ITEMS_PER_PHASE)
            begin
                it = mk_item(1'($urandom_range(0, 1)), rand_phasor_part(), rand_phasor_part(),
                             rand_phasor_part(), rand_phasor_part());
                push_item(it, 1'b0, '0);
            end
        end

        end_burst();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("PASS cable_pi_two_port_solver");
        else
            $display("FAIL cable_pi_two_port_solver");
        $finish;
    end

endmodule

`default_nettype wire
